[sv/hopf_pkg.sv]
// Shared types and constants for the Hopfield associative memory block.
// No dependencies; imported by hopfield_associative_memory_unit.
package hopf_pkg;

    localparam int NEURONS_DEF     = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int PATTERN_BITS = 16;
    localparam int SIZE_BITS    = 5;
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;

    localparam logic OP_PRESENT = 1'b0;
    localparam logic OP_TRAIN   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

[sv/hopfield_associative_memory_unit.sv]
// Hopfield associative memory: row-wide weight RAM, train and recall sequencer.
// Depends on hopf_pkg.
// Usage:
//   Input beats arrive on s_tvalid/s_tready: s_tdata is the pattern, s_tuser the
//   operation (0 = recall, 1 = train). Every input beat yields one output beat on
//   m_tvalid/m_tready: m_tdata holds the recalled bits (zero for train), m_tuser
//   flags a size error (active size zero, nothing done).
//   cfg_wr_en/cfg_wr_data write active_size; write only while the block is idle.
// Sequence:
//   The weight RAM holds one matrix row per word and is read one row per cycle,
//   so an item with n active neurons (n = min(active_size, NEURONS)) reads n
//   rows, then passes a drain state and a finish state that loads the output
//   register; a new beat is taken only once the block is back in idle. A
//   size-error item goes straight from idle to the finish state.
// Reset: aresetn (synchronous, active low) clears the row valid bits, so every
//   weight reads as zero, and sets active_size to 16.
// Stall:
//   The output register holds a result while m_tready is low; the next item is
//   accepted and computed meanwhile, and waits at its end until the register frees.
module hopfield_associative_memory_unit #(
    parameter int NEURONS     = hopf_pkg::NEURONS_DEF,
    parameter int WEIGHT_BITS = hopf_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [hopf_pkg::SIZE_BITS-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hopf_pkg::PATTERN_BITS-1:0] s_tdata,   // [15:0] pattern
    input  logic                              s_tuser,   // [0] operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hopf_pkg::PATTERN_BITS-1:0] m_tdata,   // [15:0] recalled
    output logic                              m_tuser    // [0] size_error
);
    import hopf_pkg::*;

    localparam int IW = $clog2(NEURONS);
    localparam int CW = ((IW > SIZE_BITS) ? IW : SIZE_BITS) + 1;
    localparam int AW = WEIGHT_BITS + $clog2(NEURONS) + 1;
    localparam int RW = NEURONS * WEIGHT_BITS;
    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    // weight RAM: one row of W per word
    logic [RW-1:0] mem [NEURONS];

    state_t state_reg, state_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic                 op_reg, op_next;
    logic [NEURONS-1:0]   pat_reg, pat_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic                 err_reg, err_next;
    logic [SIZE_BITS-1:0] cfg_size_reg;
    logic [NEURONS-1:0]   valid_reg;

    logic                 rvalid_reg;
    logic [IW-1:0]        rrow_reg;
    logic [RW-1:0]        rd_data_reg;
    logic                 rvld_reg;

    logic signed [AW-1:0] acc_reg [NEURONS];
    logic signed [AW-1:0] acc_next [NEURONS];

    logic                    out_valid_reg, out_valid_next;
    logic [PATTERN_BITS-1:0] out_data_reg, out_data_next;
    logic                    out_err_reg, out_err_next;

    logic                 accept, issue, load_out, last;
    logic [SIZE_BITS-1:0] eff_size;
    logic [NEURONS-1:0]   pat_in, act;
    logic signed [WEIGHT_BITS-1:0] w_cur [NEURONS];
    logic [RW-1:0]        wr_data;
    logic                 wr_en;
    logic [PATTERN_BITS-1:0] rec_bits;

    assign accept   = s_tvalid && s_tready;
    assign eff_size = (int'(cfg_size_reg) > NEURONS) ? SIZE_BITS'(NEURONS) : cfg_size_reg;
    assign last     = (CW'(cnt_reg) + CW'(1)) == CW'(size_reg);

    always_comb begin
        for (int k = 0; k < NEURONS; k++) begin
            pat_in[k] = (k < PATTERN_BITS) ? s_tdata[k % PATTERN_BITS] : 1'b0;
            act[k]    = k < int'(size_reg);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (eff_size == '0) ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_RUN:    issue    = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: load_out = !out_valid_reg || m_tready;
            default:   ;
        endcase
    end

    // item registers and row counter
    always_comb begin
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        pat_next  = pat_reg;
        size_next = size_reg;
        err_next  = err_reg;
        if (accept) begin
            cnt_next  = '0;
            op_next   = s_tuser;
            pat_next  = pat_in;
            size_next = eff_size;
            err_next  = (eff_size == '0);
        end else if (issue && !last) begin
            cnt_next = cnt_reg + IW'(1);
        end
    end

    // row update: train adds +1/-1 with saturation, recall accumulates columns
    always_comb begin
        for (int j = 0; j < NEURONS; j++) begin
            w_cur[j] = rvld_reg ? rd_data_reg[j*WEIGHT_BITS +: WEIGHT_BITS] : '0;
        end
        for (int j = 0; j < NEURONS; j++) begin
            wr_data[j*WEIGHT_BITS +: WEIGHT_BITS] = w_cur[j];
            if (act[j] && (j != int'(rrow_reg))) begin
                if (pat_reg[rrow_reg] == pat_reg[j]) begin
                    if (w_cur[j] != W_MAX) begin
                        wr_data[j*WEIGHT_BITS +: WEIGHT_BITS] = w_cur[j] + WEIGHT_BITS'(1);
                    end
                end else begin
                    if (w_cur[j] != W_MIN) begin
                        wr_data[j*WEIGHT_BITS +: WEIGHT_BITS] = w_cur[j] - WEIGHT_BITS'(1);
                    end
                end
            end
        end
        wr_en = rvalid_reg && (op_reg == OP_TRAIN);
        for (int j = 0; j < NEURONS; j++) begin
            acc_next[j] = acc_reg[j];
            if (accept) begin
                acc_next[j] = '0;
            end else if (rvalid_reg && (op_reg == OP_PRESENT) && pat_reg[rrow_reg]) begin
                acc_next[j] = acc_reg[j] + AW'(w_cur[j]);
            end
        end
    end

    // threshold and output register
    always_comb begin
        for (int k = 0; k < PATTERN_BITS; k++) begin
            rec_bits[k] = (k < NEURONS) ? (act[k % NEURONS] && (acc_reg[k % NEURONS] > 0))
                                        : 1'b0;
        end
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_err_next   = err_reg;
            out_data_next  = (err_reg || (op_reg == OP_TRAIN)) ? '0 : rec_bits;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_size_reg  <= SIZE_RESET;
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rvalid_reg    <= issue;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                cfg_size_reg <= cfg_wr_data;
            end
            if (wr_en) begin
                valid_reg[rrow_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        op_reg       <= op_next;
        pat_reg      <= pat_next;
        size_reg     <= size_next;
        err_reg      <= err_next;
        rrow_reg     <= cnt_reg;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
        for (int j = 0; j < NEURONS; j++) begin
            acc_reg[j] <= acc_next[j];
        end
        if (issue) begin
            rvld_reg <= valid_reg[cnt_reg];
        end
    end

    // RAM ports: read row at the counter, write back the updated row
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[cnt_reg];
        end
        if (wr_en) begin
            mem[rrow_reg] <= wr_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule

[tb/hopfield_associative_memory_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hopfield_associative_memory_unit: directed train/recall beats,
// associative random traffic over many active sizes and a repeated train burst on one pattern.
// Depends on hopf_pkg and the block itself; holds its own weight-matrix predictor.
module hopfield_associative_memory_unit_tb;
    import hopf_pkg::*;

    localparam int NEURONS     = NEURONS_DEF;
    localparam int WEIGHT_BITS = WEIGHT_BITS_DEF;
    localparam int W_MAX       = 2 ** (WEIGHT_BITS - 1) - 1;
    localparam int W_MIN       = -W_MAX - 1;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic                    op;
        logic [PATTERN_BITS-1:0] pattern;
    } beat_t;

    typedef struct packed {
        logic [PATTERN_BITS-1:0] recalled;
        logic                    size_error;
    } recall_t;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [SIZE_BITS-1:0]    cfg_wr_data = '0;
    logic                    s_tvalid    = 1'b0;
    logic                    s_tready;
    logic [PATTERN_BITS-1:0] s_tdata     = '0;   // [15:0] pattern
    logic                    s_tuser     = 1'b0; // [0] operation
    logic                    m_tvalid;
    logic                    m_tready    = 1'b0;
    logic [PATTERN_BITS-1:0] m_tdata;            // [15:0] recalled
    logic                    m_tuser;            // [0] size_error

    // predictor state
    logic signed [WEIGHT_BITS-1:0] weight_mem [NEURONS][NEURONS];
    logic [SIZE_BITS-1:0]          size_reg = SIZE_RESET;

    beat_t   beat_q[$];
    recall_t recall_q[$];
    beat_t   next_beat;
    recall_t want;

    bit steady     = 1'b0;
    int mismatches = 0;
    int n_train    = 0;
    int n_present  = 0;
    int n_error    = 0;
    int n_settings = 0;
    int quiet      = 0;

    hopfield_associative_memory_unit #(
        .NEURONS    (NEURONS),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic recall_t hopfield_predict(logic op, logic [PATTERN_BITS-1:0] pat);
        recall_t r;
        int      n;
        int      acc;
        r = '0;
        n = (size_reg > NEURONS) ? NEURONS : int'(size_reg);
        if (n == 0) begin
            r.size_error = 1'b1;
            return r;
        end
        if (op == OP_TRAIN) begin
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    if (i != j) begin
                        acc = int'(weight_mem[i][j]) + ((pat[i] == pat[j]) ? 1 : -1);
                        if (acc > W_MAX) acc = W_MAX;
                        if (acc < W_MIN) acc = W_MIN;
                        weight_mem[i][j] = acc[WEIGHT_BITS-1:0];
                    end
                end
            end
        end else begin
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int i = 0; i < n; i++) begin
                    if (pat[i]) acc += int'(weight_mem[i][j]);
                end
                if (acc > 0) r.recalled[j] = 1'b1;
            end
        end
        return r;
    endfunction

    // driver: predict on every accepted beat, then offer the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                recall_q.insert(recall_q.size(), hopfield_predict(s_tuser, s_tdata));
                if (size_reg == 0) n_error++;
                else if (s_tuser == OP_TRAIN) n_train++;
                else n_present++;
            end
            if (!s_tvalid || s_tready) begin
                if (beat_q.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
                    next_beat = beat_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_beat.pattern;
                    s_tuser  <= next_beat.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest recall expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (recall_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, got recalled %h error %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = recall_q.pop_front();
                    if (m_tdata !== want.recalled) begin
                        mismatches++;
                        $display("%0t: recalled mismatch, expected %h, got %h",
                                 $time, want.recalled, m_tdata);
                    end
                    if (m_tuser !== want.size_error) begin
                        mismatches++;
                        $display("%0t: size_error mismatch, expected %b, got %b",
                                 $time, want.size_error, m_tuser);
                    end
                end
            end
            m_tready <= steady || $urandom_range(99) >= 31;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == STALL_LIMIT) begin
                $display("hopfield_associative_memory_unit_tb failed");
                $finish;
            end
        end
    end

    task automatic push_beat(input logic op, input logic [PATTERN_BITS-1:0] pat);
        beat_t b;
        b.op      = op;
        b.pattern = pat;
        beat_q.insert(beat_q.size(), b);
    endtask

    // hold until the sender is empty and every expected beat has returned
    task automatic wait_drained();
        while (beat_q.size() != 0 || s_tvalid || recall_q.size() != 0) @(negedge aclk);
    endtask

    task automatic set_size(input logic [SIZE_BITS-1:0] v);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        size_reg = v;
        n_settings++;
    endtask

    // a few stored patterns, trained and recalled with noise, mixed with raw beats
    task automatic run_phase(input logic [SIZE_BITS-1:0] v, input int count);
        logic [PATTERN_BITS-1:0] stored [3];
        logic [PATTERN_BITS-1:0] pat;
        int                      r;
        int                      s;
        int                      bitpos;
        set_size(v);
        foreach (stored[k]) stored[k] = PATTERN_BITS'($urandom);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            s = $urandom_range(2);
            if (r < 25) begin
                push_beat(OP_TRAIN, stored[s]);
            end else if (r < 70) begin
                pat = stored[s];
                repeat ($urandom_range(2)) begin
                    bitpos = $urandom_range(PATTERN_BITS - 1);
                    pat[bitpos] = ~pat[bitpos];
                end
                push_beat(OP_PRESENT, pat);
            end else begin
                push_beat(logic'($urandom_range(1)), PATTERN_BITS'($urandom));
            end
        end
    endtask

    initial begin
        logic [PATTERN_BITS-1:0] hi;
        int                      pinned;
        foreach (weight_mem[i, j]) weight_mem[i][j] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty matrix, then all-ones, all-zeros and mixed-pattern training
        push_beat(OP_PRESENT, 16'h0000);
        push_beat(OP_PRESENT, 16'hFFFF);
        push_beat(OP_TRAIN,   16'hFFFF);
        push_beat(OP_PRESENT, 16'h0001);
        push_beat(OP_TRAIN,   16'h0000);
        push_beat(OP_TRAIN,   16'h00FF);
        push_beat(OP_PRESENT, 16'h00FF);
        push_beat(OP_PRESENT, 16'hFF00);
        push_beat(OP_TRAIN,   16'h5555);
        push_beat(OP_PRESENT, 16'hAAAA);
        push_beat(OP_PRESENT, 16'h8000);
        push_beat(OP_TRAIN,   16'h8001);
        push_beat(OP_PRESENT, 16'h7FFE);
        // zero size: every beat is an error and leaves the weights alone
        set_size(5'd0);
        push_beat(OP_TRAIN,   16'hFFFF);
        push_beat(OP_PRESENT, 16'hFFFF);
        // size above the neuron count clamps to it
        set_size(5'd31);
        push_beat(OP_PRESENT, 16'hFFFF);
        push_beat(OP_TRAIN,   16'h1234);
        // bits above the active size are ignored
        set_size(5'd5);
        push_beat(OP_PRESENT, 16'hFFE0);
        push_beat(OP_TRAIN,   16'hFFE3);
        push_beat(OP_PRESENT, 16'h001F);
        push_beat(OP_PRESENT, 16'hFFFF);
        set_size(5'd1);
        push_beat(OP_TRAIN,   16'hFFFF);
        push_beat(OP_PRESENT, 16'hFFFF);

        run_phase(5'd16, 200);
        run_phase(5'd4,  170);
        run_phase(5'd1,  60);
        run_phase(5'd31, 170);
        run_phase(5'd9,  170);
        run_phase(5'd0,  20);
        run_phase(5'd2,  150);
        steady = 1'b1;
        run_phase(5'd17, 200);
        wait_drained();
        steady = 1'b0;
        run_phase(5'd7,  170);
        run_phase(5'd13, 170);
        run_phase(5'd3,  170);
        run_phase(5'd16, 200);

        // push W[0][1] down and W[0][2] up with one repeated pattern
        set_size(5'd3);
        steady = 1'b1;
        repeat (60) begin
            hi = PATTERN_BITS'($urandom);
            push_beat(OP_TRAIN, {hi[PATTERN_BITS-1:3], 3'b101});
        end
        wait_drained();
        steady = 1'b0;
        push_beat(OP_PRESENT, 16'h0001);
        push_beat(OP_PRESENT, 16'h0007);
        push_beat(OP_PRESENT, 16'hFFF2);
        push_beat(OP_TRAIN,   16'h0003);
        push_beat(OP_PRESENT, 16'h0006);
        run_phase(5'd16, 60);

        wait_drained();
        repeat (40) @(posedge aclk);
        pinned = 0;
        foreach (weight_mem[i, j]) begin
            if (weight_mem[i][j] == W_MAX || weight_mem[i][j] == W_MIN) pinned++;
        end
        $display("Covered %0d train, %0d recall and %0d size-error beats across %0d size settings,",
                 n_train, n_present, n_error, n_settings);
        $display("ending with %0d weights held at a saturation limit; %0d mismatches.",
                 pinned, mismatches);
        if (mismatches == 0) begin
            $display("hopfield_associative_memory_unit_tb passed");
        end else begin
            $display("hopfield_associative_memory_unit_tb failed");
        end
        $finish;
    end

endmodule
